// ===== hw/rtl/sssc_pkg.sv =====
// Shared types, constants and the digit code table of the scan controller.
package sssc_pkg;

  // Item modes
  localparam logic [1:0] MODE_TICK = 2'd0;
  localparam logic [1:0] MODE_NUM  = 2'd1;
  localparam logic [1:0] MODE_LED  = 2'd2;

  // Key codes reported on a tick
  localparam logic [2:0] KEY_NONE = 3'd0;
  localparam logic [2:0] KEY_CH0  = 3'd1;
  localparam logic [2:0] KEY_CH7  = 3'd2;
  localparam logic [2:0] KEY_CH8  = 3'd3;
  localparam logic [2:0] KEY_CH9  = 3'd4;

  // Store and scan geometry
  localparam int unsigned StoreDepth = 9;
  localparam int unsigned AddrW      = 4;
  localparam logic [AddrW-1:0] LED_SLOT   = 4'd8;
  localparam logic [AddrW-1:0] LAST_SLOT  = 4'd9;
  localparam logic [AddrW-1:0] CHAN_SEVEN = 4'd7;
  localparam logic [AddrW-1:0] CHAN_ZERO  = 4'd0;

  // Number conversion
  localparam logic [13:0] MAX_SHOWN = 14'd9999;
  localparam int unsigned BinW      = 14;
  localparam int unsigned BcdW      = 16;
  localparam int unsigned StepW     = 4;
  localparam logic [StepW-1:0] LAST_STEP = 4'd13;

  localparam logic [7:0] SEG_BLANK = 8'h00;

  typedef struct packed {
    logic [1:0]  mode;
    logic [13:0] value;
    logic        half;
    logic [3:0]  leds;
    logic        switch_low;
  } in_item_t;

  typedef struct packed {
    logic [7:0] segment_byte;
    logic [3:0] digit_select;
    logic [2:0] key;
  } out_item_t;

  // Store access request from the controller
  typedef struct packed {
    logic             re;
    logic [AddrW-1:0] raddr;
    logic             we;
    logic [AddrW-1:0] waddr;
    logic [7:0]       wdata;
  } mem_req_t;

  // Segment pattern of one decimal digit
  function automatic logic [7:0] seg_code(input logic [3:0] d);
    logic [7:0] c;
    case (d)
      4'd0: c = 8'hED;
      4'd1: c = 8'h21;
      4'd2: c = 8'h8F;
      4'd3: c = 8'hAB;
      4'd4: c = 8'h63;
      4'd5: c = 8'hEA;
      4'd6: c = 8'hEE;
      4'd7: c = 8'hA1;
      4'd8: c = 8'hEF;
      4'd9: c = 8'hEB;
      default: c = SEG_BLANK;
    endcase
    return c;
  endfunction

endpackage

// ===== hw/rtl/sssc_store.sv =====
// Display store: nine segment bytes, one write and one registered read port.
module sssc_store
  import sssc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mem_req_t req_i,
  output logic [7:0] rdata_o
);

  logic [7:0]            mem_q [StoreDepth];
  logic [StoreDepth-1:0] valid_q;
  logic [7:0]            rdata_q;

  // Payload array, no reset
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  // Written flags; an unwritten entry reads blank
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (req_i.we) begin
      valid_q[req_i.waddr] <= 1'b1;
    end
  end

  // Registered read
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= valid_q[req_i.raddr] ? mem_q[req_i.raddr] : SEG_BLANK;
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/sssc_bcd.sv =====
// Iterative binary to BCD converter, one shift-add-3 step per cycle.
module sssc_bcd
  import sssc_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [BinW-1:0] value_i,
  output logic            done_o,
  output logic [BcdW-1:0] bcd_o
);

  logic                 busy_q, done_q;
  logic [StepW-1:0]     cnt_q;
  logic [BcdW+BinW-1:0] shift_q, shift_d;
  logic [BcdW-1:0]      adj;

  // Add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < BcdW / 4; i++) begin
      adj[4*i +: 4] = (shift_q[BinW + 4*i +: 4] >= 4'd5) ?
                      shift_q[BinW + 4*i +: 4] + 4'd3 : shift_q[BinW + 4*i +: 4];
    end
    shift_d = {adj, shift_q[BinW-1:0]} << 1;
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LAST_STEP) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Shift register
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      shift_q <= {{BcdW{1'b0}}, value_i};
    end else if (busy_q) begin
      shift_q <= shift_d;
    end
  end

  assign done_o = done_q;
  assign bcd_o  = shift_q[BcdW+BinW-1:BinW];

endmodule

// ===== hw/rtl/seven_segment_scan_controller.sv =====
// Top level: multiplexed seven-segment display and key scan controller.
//
// Input channel (in_valid_i / in_stall_o / in_item_i) takes one item at a
// time: a tick, a set-number or a set-LED item. Only a tick yields a result,
// on the output channel (out_valid_o / out_stall_i / out_item_o), which holds
// the slot's segment byte, its decoder channel and any key seen.
// The store sits in a synchronous memory with a registered read; the
// controller below runs the store reads and writes of each item.
// Tick: the slot is read on accept (slot 9 is not read and shows blank);
//   the output register is loaded once it is free, then back to idle.
// Set LEDs: read slot 8, then write it back with the four LED bits changed.
// Set number: 14 conversion steps, the done flag, then 4 digit writes over
//   the single write port; a value above 9999 changes nothing.
// Reset blanks the whole store at once through per-entry written flags and
// sets the scan to slot 0; no clearing pass is needed.
// While a result waits under out_stall_i the block still takes set items; a
// tick holds in_stall_o high until the waiting result has been taken.
module seven_segment_scan_controller
  import sssc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_TICK = 3'd1;
  localparam logic [2:0] S_BCD  = 3'd2;
  localparam logic [2:0] S_WR   = 3'd3;
  localparam logic [2:0] S_LED  = 3'd4;

  logic [2:0]       state_q, state_d;
  logic [AddrW-1:0] slot_q, slot_d;
  logic [1:0]       k_q, k_d;
  in_item_t         item_q;
  logic             out_valid_q, out_valid_d;
  out_item_t        out_q, out_d;

  logic             accept, out_free, bcd_start, bcd_done;
  logic [BcdW-1:0]  bcd;
  logic [7:0]       rdata;
  logic [2:0]       digits;
  mem_req_t         req;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign bcd_start  = accept && (in_item_i.mode == MODE_NUM) && (in_item_i.value <= MAX_SHOWN);

  sssc_store u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req),
    .rdata_o (rdata)
  );

  sssc_bcd u_bcd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (bcd_start),
    .value_i (in_item_i.value),
    .done_o  (bcd_done),
    .bcd_o   (bcd)
  );

  // Number of digits shown, leading zeros blanked
  always_comb begin
    if (item_q.value >= 14'd1000)     digits = 3'd4;
    else if (item_q.value >= 14'd100) digits = 3'd3;
    else if (item_q.value >= 14'd10)  digits = 3'd2;
    else                              digits = 3'd1;
  end

  // Sequencer and store requests
  always_comb begin
    state_d     = state_q;
    slot_d      = slot_q;
    k_d         = k_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    req         = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (in_item_i.mode)
            MODE_TICK: begin
              req.re    = (slot_q != LAST_SLOT);
              req.raddr = slot_q;
              state_d   = S_TICK;
            end
            MODE_NUM: begin
              if (bcd_start) state_d = S_BCD;
            end
            MODE_LED: begin
              req.re    = 1'b1;
              req.raddr = LED_SLOT;
              state_d   = S_LED;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_TICK: begin
        if (out_free) begin
          out_valid_d        = 1'b1;
          out_d.segment_byte = (slot_q == LAST_SLOT) ? SEG_BLANK : rdata;
          out_d.digit_select = slot_q;
          out_d.key          = KEY_NONE;
          if (item_q.switch_low) begin
            if (slot_q == CHAN_ZERO)       out_d.key = KEY_CH0;
            else if (slot_q == CHAN_SEVEN) out_d.key = KEY_CH7;
            else if (slot_q == LED_SLOT)   out_d.key = KEY_CH8;
            else if (slot_q == LAST_SLOT)  out_d.key = KEY_CH9;
          end
          slot_d  = (slot_q == LAST_SLOT) ? CHAN_ZERO : slot_q + 1'b1;
          state_d = S_IDLE;
        end
      end
      S_BCD: begin
        if (bcd_done) begin
          k_d     = 2'd0;
          state_d = S_WR;
        end
      end
      S_WR: begin
        req.we    = 1'b1;
        req.waddr = {1'b0, item_q.half, k_q};
        req.wdata = ({1'b0, k_q} < digits) ? seg_code(bcd[4*k_q +: 4]) : SEG_BLANK;
        k_d       = k_q + 1'b1;
        if (k_q == 2'd3) state_d = S_IDLE;
      end
      S_LED: begin
        req.we    = 1'b1;
        req.waddr = LED_SLOT;
        req.wdata = {item_q.leds[0], item_q.leds[1], rdata[5:4],
                     item_q.leds[2], rdata[2], item_q.leds[3], rdata[0]};
        state_d   = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      slot_q      <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      slot_q      <= slot_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) item_q <= in_item_i;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

`ifndef SYNTHESIS
  a_we_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req.we |-> (state_q == S_WR || state_q == S_LED))
    else $error("store write outside a write state");

  a_addr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req.we || req.re) |-> ((!req.we || req.waddr <= LED_SLOT) &&
                            (!req.re || req.raddr <= LED_SLOT)))
    else $error("store address beyond last entry");

  a_tick_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_item_i.mode == MODE_TICK) |=> (state_q == S_TICK))
    else $error("tick item did not enter tick state");

  a_bcd_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bcd_done |-> (state_q == S_BCD))
    else $error("conversion finished outside conversion state");

  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_q <= LAST_SLOT)
    else $error("scan slot out of range");
`endif

endmodule

// ===== dv/tb_seven_segment_scan_controller.sv =====
// Testbench for the seven-segment scan controller: directed and random items, checked by a predictor.
`timescale 1ns / 100ps

module tb_seven_segment_scan_controller;
  import sssc_pkg::*;

  // The package names only the three modes in use
  localparam logic [1:0] MODE_RESERVED = 2'd3;

  localparam int unsigned RandomItems = 1100;
  localparam int unsigned TailItems   = 120;   // last items go without idling
  localparam int unsigned DrainCycles = 40;    // set-number yields no result to wait for
  localparam int unsigned StallLimit  = 4000;

  localparam logic [7:0] DigitPattern [10] = '{
    8'hED, 8'h21, 8'h8F, 8'hAB, 8'h63, 8'hEA, 8'hEE, 8'hA1, 8'hEF, 8'hEB
  };
  localparam logic [7:0] LedMask [4] = '{8'h80, 8'h40, 8'h08, 8'h02};

  typedef struct {
    in_item_t item;
    bit       drain_first;  // hold the item back until no result is outstanding
  } planned_item_t;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_item_t  in_item_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_item_o;

  planned_item_t items_to_send [$];
  out_item_t     scan_frames_due [$];

  // Predicted block state
  logic [7:0] seg_store [StoreDepth];
  logic [3:0] scan_pos;

  int unsigned mismatch_count = 0;
  int unsigned sent_count     = 0;
  int unsigned taken_count    = 0;
  int unsigned send_gap       = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned stall_left     = 0;
  int unsigned stall_pct      = 0;
  int unsigned idle_cycles    = 0;

  seven_segment_scan_controller u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic bit in_quiet_tail();
    return items_to_send.size() < TailItems;
  endfunction

  function automatic in_item_t make_item(logic [1:0] mode, logic [13:0] value, logic half,
                                         logic [3:0] leds, logic sw);
    in_item_t it;
    it.mode       = mode;
    it.value      = value;
    it.half       = half;
    it.leds       = leds;
    it.switch_low = sw;
    return it;
  endfunction

  function automatic void plan_item(in_item_t it, bit drain);
    planned_item_t p;
    p.item        = it;
    p.drain_first = drain;
    items_to_send.push_back(p);
  endfunction

  // Random item; set-number values mostly spread evenly over digit counts
  function automatic in_item_t random_item();
    in_item_t    it;
    int unsigned pick;
    it = make_item(MODE_TICK, 14'($urandom_range(0, 16383)), 1'($urandom),
                   4'($urandom), 1'($urandom));
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      it.mode = MODE_TICK;
    end else if (pick < 80) begin
      it.mode = MODE_NUM;
      case ($urandom_range(0, 9))
        0, 1: ;  // keep the full 14-bit range, out-of-range values included
        2, 3: it.value = 14'($urandom_range(0, 9));
        4, 5: it.value = 14'($urandom_range(10, 99));
        6, 7: it.value = 14'($urandom_range(100, 999));
        default: it.value = 14'($urandom_range(1000, 9999));
      endcase
    end else if (pick < 95) begin
      it.mode = MODE_LED;
    end else begin
      it.mode = MODE_RESERVED;
    end
    return it;
  endfunction

  // Update the predicted store and scan for one accepted item
  function automatic void predict_display_item(in_item_t it);
    out_item_t   frame;
    int unsigned v;
    int unsigned ndig;
    int unsigned base;
    case (it.mode)
      MODE_NUM: begin
        if (it.value <= MAX_SHOWN) begin
          v    = it.value;
          ndig = (v >= 1000) ? 4 : (v >= 100) ? 3 : (v >= 10) ? 2 : 1;
          base = it.half ? 4 : 0;
          for (int k = 0; k < 4; k++) begin
            seg_store[base + k] = (k < ndig) ? DigitPattern[v % 10] : SEG_BLANK;
            v = v / 10;
          end
        end
      end
      MODE_LED: begin
        for (int k = 0; k < 4; k++) begin
          if (it.leds[k]) seg_store[LED_SLOT] |= LedMask[k];
          else seg_store[LED_SLOT] &= ~LedMask[k];
        end
      end
      MODE_TICK: begin
        // channel nine has no store entry and reads blank
        frame.segment_byte = (scan_pos < StoreDepth) ? seg_store[scan_pos] : SEG_BLANK;
        frame.digit_select = scan_pos;
        frame.key          = KEY_NONE;
        if (it.switch_low) begin
          case (scan_pos)
            CHAN_ZERO:  frame.key = KEY_CH0;
            CHAN_SEVEN: frame.key = KEY_CH7;
            LED_SLOT:   frame.key = KEY_CH8;
            LAST_SLOT:  frame.key = KEY_CH9;
            default:    frame.key = KEY_NONE;
          endcase
        end
        scan_frames_due.push_back(frame);
        scan_pos = (scan_pos == LAST_SLOT) ? CHAN_ZERO : scan_pos + 4'd1;
      end
      default: ;  // reserved mode: ignored
    endcase
  endfunction

  function automatic void report_field(string name, logic [7:0] want, logic [7:0] got);
    mismatch_count++;
    $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
  endfunction

  function automatic void check_scan_frame(out_item_t got);
    out_item_t want;
    if (scan_frames_due.size() == 0) begin
      mismatch_count++;
      $display("%0t: unexpected result, expected none, actual seg 0x%0h digit %0d key %0d",
               $time, got.segment_byte, got.digit_select, got.key);
      return;
    end
    want = scan_frames_due.pop_front();
    if (got.segment_byte !== want.segment_byte)
      report_field("segment_byte", want.segment_byte, got.segment_byte);
    if (got.digit_select !== want.digit_select)
      report_field("digit_select", 8'(want.digit_select), 8'(got.digit_select));
    if (got.key !== want.key)
      report_field("key", 8'(want.key), 8'(got.key));
  endfunction

  // Item driver: random idle bursts between items, drain holds where planned
  always @(posedge clk_i or negedge rst_ni) begin : drive_proc
    logic     offer;
    in_item_t next_item;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_item_i  <= '0;
    end else begin
      offer     = in_valid_i;
      next_item = in_item_i;
      if (in_valid_i && !in_stall_o) begin
        predict_display_item(in_item_i);
        offer = 1'b0;
        sent_count++;
        if (sent_count % 97 == 0) begin
          case ($urandom_range(0, 2))
            0: send_idle_pct = 0;
            1: send_idle_pct = 10;
            default: send_idle_pct = 35;
          endcase
        end
        if (!in_quiet_tail() && $urandom_range(0, 99) < send_idle_pct)
          send_gap = $urandom_range(1, 9);
      end
      if (!offer) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (items_to_send.size() != 0 &&
                     !(items_to_send[0].drain_first && scan_frames_due.size() != 0)) begin
          next_item = items_to_send[0].item;
          void'(items_to_send.pop_front());
          offer = 1'b1;
        end
      end
      in_valid_i <= offer;
      in_item_i  <= next_item;
    end
  end

  // Result monitor with random stall bursts
  always @(posedge clk_i or negedge rst_ni) begin : monitor_proc
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        check_scan_frame(out_item_o);
        taken_count++;
        if (taken_count % 89 == 0) begin
          case ($urandom_range(0, 2))
            0: stall_pct = 0;
            1: stall_pct = 10;
            default: stall_pct = 40;
          endcase
        end
      end
      if (stall_left > 0) stall_left--;
      else if (!in_quiet_tail() && $urandom_range(0, 99) < stall_pct)
        stall_left = $urandom_range(1, 9);
      out_stall_i <= (stall_left > 0);
    end
  end

  // Watchdog: too long without any item moving on either channel
  always @(posedge clk_i) begin : watchdog_proc
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("%0t: no item moved for %0d cycles", $time, StallLimit);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin : main_proc
    int unsigned counted;
    in_item_t    it;
    for (int k = 0; k < StoreDepth; k++) seg_store[k] = SEG_BLANK;
    scan_pos = CHAN_ZERO;

    // Directed: zero, largest value, out-of-range values, LEDs, reserved mode
    plan_item(make_item(MODE_NUM, 14'd0, 1'b0, 4'h0, 1'b0), 1'b0);
    plan_item(make_item(MODE_NUM, 14'd9999, 1'b1, 4'h0, 1'b0), 1'b0);
    plan_item(make_item(MODE_NUM, 14'h3FFF, 1'b0, 4'hF, 1'b1), 1'b0);
    plan_item(make_item(MODE_NUM, 14'd10000, 1'b1, 4'h0, 1'b0), 1'b0);
    plan_item(make_item(MODE_LED, 14'h0, 1'b0, 4'hF, 1'b0), 1'b0);
    plan_item(make_item(MODE_LED, 14'h3FFF, 1'b1, 4'h5, 1'b1), 1'b0);
    plan_item(make_item(MODE_RESERVED, 14'h3FFF, 1'b1, 4'hF, 1'b1), 1'b0);
    // full scan with the key line low, through the wrap back to slot 0
    for (int k = 0; k < 11; k++)
      plan_item(make_item(MODE_TICK, 14'h0, 1'b0, 4'h0, 1'b1), 1'b0);
    plan_item(make_item(MODE_TICK, 14'h3FFF, 1'b1, 4'hF, 1'b0), 1'b0);
    // leading-zero blanking
    plan_item(make_item(MODE_NUM, 14'd1234, 1'b0, 4'h0, 1'b0), 1'b0);
    plan_item(make_item(MODE_NUM, 14'd7, 1'b1, 4'h0, 1'b0), 1'b0);
    plan_item(make_item(MODE_LED, 14'h0, 1'b0, 4'h0, 1'b0), 1'b0);
    plan_item(make_item(MODE_NUM, 14'd100, 1'b0, 4'h0, 1'b0), 1'b1);
    plan_item(make_item(MODE_TICK, 14'h0, 1'b0, 4'h0, 1'b0), 1'b0);

    // Random part; reserved-mode items do not count
    counted = 0;
    while (counted < RandomItems) begin
      it = random_item();
      plan_item(it, counted == 300 || counted == 750);
      if (it.mode != MODE_RESERVED) counted++;
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (items_to_send.size() != 0 || in_valid_i || scan_frames_due.size() != 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (scan_frames_due.size() != 0)
      $display("%0t: %0d expected results never arrived", $time, scan_frames_due.size());
    if (mismatch_count == 0 && scan_frames_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
